>>> rtl/hevc_rtp_fragmenter_top_defines.svh
// assertion macros for the fragmenter
`ifndef HEVC_RTP_FRAGMENTER_TOP_DEFINES_SVH
`define HEVC_RTP_FRAGMENTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define HRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrf assertion failed");
`define HRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrf assertion failed");
`else
`define HRF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/hrf_pkg.sv
package hrf_pkg;

  localparam int LEN_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0]  FU_TYPE_BYTE = 8'd98;
  localparam logic [15:0] FU_HDR_LEN   = 16'd3;
  localparam logic [15:0] MIN_PAYLOAD  = 16'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE  = 2'd2;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             first_of_unit;
    logic [LEN_W-1:0] unit_length;
    logic [31:0]      pts;
    logic             meta_unit;
    logic             frame_begin;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_first;
    logic       packet_last;
    logic       marker_bit;
    logic       frame_start_flag;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic [2:0]       n;
    res_t [3:0]       ent;
    logic [15:0]      seq_number;
    logic [31:0]      rtp_time;
  } step_t;

endpackage

>>> rtl/hrf_engine.sv
module hrf_engine import hrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  item_t       item,
  input  logic [15:0] max_payload,
  output step_t       step
);

  logic             fragment_mode_r, fragment_mode_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [15:0]      chunk_fill_r, chunk_fill_nxt;
  logic [5:0]       saved_type_r, saved_type_nxt;
  logic [7:0]       saved_indicator_r, saved_indicator_nxt;
  logic [15:0]      next_seq_r, next_seq_nxt;
  logic [31:0]      prev_time_r, prev_time_nxt;
  logic [31:0]      unit_time_r, unit_time_nxt;
  logic [1:0]       unit_flags_r, unit_flags_nxt;

  logic [15:0] maxp;
  logic [15:0] room;

  assign maxp = (max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload;
  assign room = maxp - FU_HDR_LEN;

  always_comb begin
    logic [LEN_W-1:0] len;
    logic             proc;
    logic             endc;
    logic             hdr;
    fragment_mode_nxt   = fragment_mode_r;
    bytes_left_nxt      = bytes_left_r;
    chunk_fill_nxt      = chunk_fill_r;
    saved_type_nxt      = saved_type_r;
    saved_indicator_nxt = saved_indicator_r;
    next_seq_nxt        = next_seq_r;
    prev_time_nxt       = prev_time_r;
    unit_time_nxt       = unit_time_r;
    unit_flags_nxt      = unit_flags_r;
    step                = '0;
    proc                = 1'b0;
    endc                = 1'b0;
    hdr                 = 1'b0;
    len = (item.unit_length == '0) ? LEN_W'(1) : item.unit_length;
    if (adv) begin
      if (item.first_of_unit) begin
        unit_time_nxt = item.pts;
        prev_time_nxt = item.pts;
        chunk_fill_nxt = '0;
        if (len <= LEN_W'(maxp)) begin
          fragment_mode_nxt = 1'b0;
          unit_flags_nxt = {item.frame_begin,
                            (!item.meta_unit && (item.pts != prev_time_r))};
          bytes_left_nxt = len;
          proc = 1'b1;
        end else begin
          fragment_mode_nxt = 1'b1;
          saved_type_nxt = item.data_byte[6:1];
          unit_flags_nxt = 2'b11;
          bytes_left_nxt = len - LEN_W'(2);
        end
      end else if (bytes_left_r != '0) begin
        if (fragment_mode_r && unit_flags_r[0]) begin
          saved_indicator_nxt = item.data_byte;
          unit_flags_nxt[0] = 1'b0;
        end else begin
          proc = 1'b1;
        end
      end

      if (proc) begin
        if (!fragment_mode_nxt) begin
          step.ent[0] = '{item.data_byte, item.first_of_unit,
                          (bytes_left_nxt == LEN_W'(1)), unit_flags_nxt[0],
                          unit_flags_nxt[1], 1'b1};
          step.n = 3'd1;
          bytes_left_nxt = bytes_left_nxt - LEN_W'(1);
          if (bytes_left_nxt == '0) begin
            next_seq_nxt = next_seq_r + 16'd1;
          end
        end else begin
          if (chunk_fill_nxt == '0) begin
            hdr = 1'b1;
            endc = (bytes_left_nxt <= LEN_W'(room));
            chunk_fill_nxt = endc ? bytes_left_nxt[15:0] : room;
            step.ent[0] = '{FU_TYPE_BYTE, 1'b1, 1'b0, endc, 1'b0, 1'b0};
            step.ent[1] = '{saved_indicator_r, 1'b0, 1'b0, endc, 1'b0, 1'b0};
            step.ent[2] = '{{unit_flags_nxt[1], endc, saved_type_r},
                            1'b0, 1'b0, endc, 1'b0, 1'b0};
            unit_flags_nxt = 2'b00;
          end
          if (hdr) begin
            step.ent[3] = '{item.data_byte, 1'b0, (chunk_fill_nxt == 16'd1),
                            (LEN_W'(chunk_fill_nxt) == bytes_left_nxt), 1'b0, 1'b1};
            step.n = 3'd4;
          end else begin
            step.ent[0] = '{item.data_byte, 1'b0, (chunk_fill_nxt == 16'd1),
                            (LEN_W'(chunk_fill_nxt) == bytes_left_nxt), 1'b0, 1'b1};
            step.n = 3'd1;
          end
          chunk_fill_nxt = chunk_fill_nxt - 16'd1;
          bytes_left_nxt = bytes_left_nxt - LEN_W'(1);
          if (chunk_fill_nxt == '0) begin
            next_seq_nxt = next_seq_r + 16'd1;
          end
          if (bytes_left_nxt == '0) begin
            fragment_mode_nxt = 1'b0;
            chunk_fill_nxt = '0;
          end
        end
      end
    end
    step.seq_number = next_seq_r;
    step.rtp_time   = unit_time_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fragment_mode_r   <= 1'b0;
      bytes_left_r      <= '0;
      chunk_fill_r      <= '0;
      saved_type_r      <= '0;
      saved_indicator_r <= '0;
      next_seq_r        <= '0;
      prev_time_r       <= '0;
      unit_time_r       <= '0;
      unit_flags_r      <= '0;
    end else begin
      fragment_mode_r   <= fragment_mode_nxt;
      bytes_left_r      <= bytes_left_nxt;
      chunk_fill_r      <= chunk_fill_nxt;
      saved_type_r      <= saved_type_nxt;
      saved_indicator_r <= saved_indicator_nxt;
      next_seq_r        <= next_seq_nxt;
      prev_time_r       <= prev_time_nxt;
      unit_time_r       <= unit_time_nxt;
      unit_flags_r      <= unit_flags_nxt;
    end
  end

endmodule

>>> rtl/hevc_rtp_fragmenter_top.sv
// H.265 RTP payload fragmenter. NAL bytes (no start code) enter one per request;
// the first byte of a unit carries its length, decode time and flags. A unit
// no longer than max_payload leaves as one packet; a longer one becomes
// fragmentation units with a 3-byte header ahead of each chunk. Rate: one
// byte per cycle while out_ready is high and no chunk header is draining.
// The two NAL header bytes of a fragmented unit yield nothing; the first
// data byte of each chunk yields four results and holds the input while
// the buffer drains one result per cycle as out_ready allows. An input register
// with the time-scale multiplier ahead of it feeds the packetizing logic into
// a four-entry result buffer. Configuration writes are always accepted.
`include "hevc_rtp_fragmenter_top_defines.svh"

module hevc_rtp_fragmenter_top import hrf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_of_unit,
  input  logic [LEN_W-1:0]     in_unit_length,
  input  logic [31:0]          in_decode_time,
  input  logic                 in_meta_unit,
  input  logic                 in_frame_begin,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_packet_first,
  output logic                 out_packet_last,
  output logic [15:0]          out_seq_number,
  output logic [31:0]          out_rtp_time,
  output logic                 out_marker_bit,
  output logic                 out_frame_start_flag,
  output logic                 out_run_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  logic [15:0] max_payload_r;
  logic        fast_time_r;
  logic [15:0] time_scale_r;

  logic        valid_a_r;
  item_t       item_r;

  res_t [3:0]  ent_r;
  logic [1:0]  idx_r;
  logic [2:0]  rem_r;
  logic [15:0] seq_r;
  logic [31:0] time_r;

  logic [31:0] prod;
  logic        take;
  logic        buf_free;
  logic        adv_b;
  step_t       step;
  res_t        cur;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= 16'd1400;
      fast_time_r   <= 1'b0;
      time_scale_r  <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_data;
        CFG_FAST_TIME:   fast_time_r   <= cfg_data[0];
        CFG_TIME_SCALE:  time_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign prod     = in_decode_time * {16'b0, time_scale_r};
  assign take     = out_valid && out_ready;
  assign buf_free = (rem_r == 3'd0) || ((rem_r == 3'd1) && take);
  assign adv_b    = valid_a_r && buf_free;
  assign in_ready = !valid_a_r || buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_a_r <= 1'b1;
    end else if (adv_b) begin
      valid_a_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{in_data_byte, in_first_of_unit, in_unit_length,
                  (fast_time_r ? prod : in_decode_time),
                  in_meta_unit, in_frame_begin};
    end
  end

  hrf_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv_b),
    .item        (item_r),
    .max_payload (max_payload_r),
    .step        (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (adv_b && (step.n != 3'd0)) begin
      rem_r <= step.n;
      idx_r <= 2'd0;
    end else if (take) begin
      rem_r <= rem_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && (step.n != 3'd0)) begin
      ent_r  <= step.ent;
      seq_r  <= step.seq_number;
      time_r <= step.rtp_time;
    end
  end

  assign cur                  = ent_r[idx_r];
  assign out_valid            = (rem_r != 3'd0);
  assign out_byte             = cur.out_byte;
  assign out_packet_first     = cur.packet_first;
  assign out_packet_last      = cur.packet_last;
  assign out_marker_bit       = cur.marker_bit;
  assign out_frame_start_flag = cur.frame_start_flag;
  assign out_run_last         = cur.run_last;
  assign out_seq_number       = seq_r;
  assign out_rtp_time         = time_r;

  `HRF_ASSERT_NEXT(a_load_shows, clk, rst_n, adv_b && (step.n != 3'd0), out_valid)
  `HRF_ASSERT_NOW(a_last_marks, clk, rst_n, out_valid && (rem_r == 3'd1), out_run_last)
  `HRF_ASSERT_NOW(a_mark_is_last, clk, rst_n, out_valid && out_run_last, rem_r == 3'd1)

endmodule
